// File: rtl/core/shpc_pkg.sv
// Shared widths, pair codes, types and helpers for the shape pair collision test.
package shpc_pkg;

	// Coordinate width of every geometry field
	localparam int COORD_BITS = 16;
	// Point width: box corners are origin plus size, one bit wider
	localparam int PW = COORD_BITS + 1;
	// Difference of two points
	localparam int DW = PW + 1;
	// Product of two differences
	localparam int MW = 2 * DW;
	// Sum or difference of two products
	localparam int SW = MW + 1;
	// Half width used to split the wide squaring
	localparam int HW = MW / 2;
	// Radius width (sum of two non-negative radii fits)
	localparam int RW = COORD_BITS;
	// Width of the compared wide terms
	localparam int LW = 2 * MW + 1;

	localparam int NUM_GEOM = 10;
	localparam int TDATA_BITS = ((NUM_GEOM * COORD_BITS + 7) / 8) * 8;
	localparam int LANES = 4;

	// Pair codes
	localparam logic [3:0] KIND_PT_PT     = 4'd0;
	localparam logic [3:0] KIND_PT_SEG    = 4'd1;
	localparam logic [3:0] KIND_PT_CIRC   = 4'd2;
	localparam logic [3:0] KIND_PT_BOX    = 4'd3;
	localparam logic [3:0] KIND_PT_TRI    = 4'd4;
	localparam logic [3:0] KIND_SEG_SEG   = 4'd5;
	localparam logic [3:0] KIND_SEG_CIRC  = 4'd6;
	localparam logic [3:0] KIND_SEG_BOX   = 4'd7;
	localparam logic [3:0] KIND_SEG_TRI   = 4'd8;
	localparam logic [3:0] KIND_CIRC_CIRC = 4'd9;
	localparam logic [3:0] KIND_CIRC_BOX  = 4'd10;
	localparam logic [3:0] KIND_CIRC_TRI  = 4'd11;

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
	} point_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
	} vec_t;

	// Load enables of the lane stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// Segment crossing lane result
	typedef struct packed {
		logic crs;   // strict crossing
		logic neg0;  // first end strictly right of the edge
		logic neg1;  // second end strictly right of the edge
	} ss_res_t;

	// Segment against circle lane result
	typedef struct packed {
		logic hit;     // segment meets the open disc
		logic in_a;    // first end inside the disc
		logic on_seg;  // centre strictly inside the segment
	} sc_res_t;

	function automatic vec_t vsub(input point_t a, input point_t b);
		vec_t r;
		r.x = DW'(a.x) - DW'(b.x);
		r.y = DW'(a.y) - DW'(b.y);
		return r;
	endfunction

	function automatic logic signed [PW-1:0] sext(input logic [COORD_BITS-1:0] v);
		return {v[COORD_BITS-1], v};
	endfunction

	// Strictly opposite signs of two cross products
	function automatic logic opp(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b);
		logic an, ap, bn, bp;
		an = a[SW-1];
		ap = !a[SW-1] && (a != '0);
		bn = b[SW-1];
		bp = !b[SW-1] && (b != '0);
		return (an && bp) || (ap && bn);
	endfunction

endpackage

// File: rtl/core/shpc_seg_seg.sv
// Segment crossing lane: four cross products, signs and crossing flag.
module shpc_seg_seg import shpc_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  point_t    e0,
	input  point_t    e1,
	input  point_t    p0,
	input  point_t    p1,
	output ss_res_t   res
);

	vec_t e_s2, a_s2, b_s2, f_s2, g_s2, h_s2;
	logic signed [MW-1:0] pr_s3 [8];
	logic signed [SW-1:0] c [4];
	ss_res_t res_s4, res_s5;

	// Differences against both segment starts
	always_ff @(posedge clk) begin
		if (en.s2) begin
			e_s2 <= vsub(e1, e0);
			a_s2 <= vsub(p0, e0);
			b_s2 <= vsub(p1, e0);
			f_s2 <= vsub(p1, p0);
			g_s2 <= vsub(e0, p0);
			h_s2 <= vsub(e1, p0);
		end
	end

	// Cross product terms
	always_ff @(posedge clk) begin
		if (en.s3) begin
			pr_s3[0] <= e_s2.x * a_s2.y;
			pr_s3[1] <= e_s2.y * a_s2.x;
			pr_s3[2] <= e_s2.x * b_s2.y;
			pr_s3[3] <= e_s2.y * b_s2.x;
			pr_s3[4] <= f_s2.x * g_s2.y;
			pr_s3[5] <= f_s2.y * g_s2.x;
			pr_s3[6] <= f_s2.x * h_s2.y;
			pr_s3[7] <= f_s2.y * h_s2.x;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			c[k] = SW'(pr_s3[2*k]) - SW'(pr_s3[2*k+1]);
		end
	end

	// Signs and strict crossing, then one carry stage
	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4.crs  <= opp(c[0], c[1]) && opp(c[2], c[3]);
			res_s4.neg0 <= c[0][SW-1];
			res_s4.neg1 <= c[1][SW-1];
		end
		if (en.s5) begin
			res_s5 <= res_s4;
		end
	end

	assign res = res_s5;

endmodule

// File: rtl/core/shpc_seg_circ.sv
// Segment against circle lane: distances, dot products and exact line distance test.
module shpc_seg_circ import shpc_pkg::*; (
	input  logic          clk,
	input  stage_en_t     en,
	input  point_t        a,
	input  point_t        b,
	input  point_t        c,
	input  logic [RW-1:0] r,
	output sc_res_t       res
);

	vec_t u_s2, v_s2, w_s2;
	logic [RW-1:0] r_s2;
	logic signed [MW-1:0] pr_s3 [12];
	logic [2*RW-1:0] r2_s3;

	logic signed [SW-1:0] n, dot1, uw, len2_sg;
	logic [MW-1:0] len2, da, db, nabs;

	logic [MW-1:0] nabs_s4, len2_s4;
	logic [2*RW-1:0] r2_s4;
	logic in_a_s4, in_b_s4, d1ge_s4, d2ge_s4, onseg_s4;

	logic [MW+HW-1:0] nh_s5, nl_s5;
	logic [2*RW+HW-1:0] rh_s5, rl_s5;
	logic in_a_s5, in_b_s5, d1ge_s5, d2ge_s5, onseg_s5;
	logic [LW-1:0] lhs, rhs;

	// Edge vector and vectors to the centre
	always_ff @(posedge clk) begin
		if (en.s2) begin
			u_s2 <= vsub(b, a);
			v_s2 <= vsub(c, a);
			w_s2 <= vsub(c, b);
			r_s2 <= r;
		end
	end

	// All product terms
	always_ff @(posedge clk) begin
		if (en.s3) begin
			pr_s3[0]  <= u_s2.x * v_s2.y;
			pr_s3[1]  <= u_s2.y * v_s2.x;
			pr_s3[2]  <= u_s2.x * u_s2.x;
			pr_s3[3]  <= u_s2.y * u_s2.y;
			pr_s3[4]  <= v_s2.x * v_s2.x;
			pr_s3[5]  <= v_s2.y * v_s2.y;
			pr_s3[6]  <= w_s2.x * w_s2.x;
			pr_s3[7]  <= w_s2.y * w_s2.y;
			pr_s3[8]  <= u_s2.x * v_s2.x;
			pr_s3[9]  <= u_s2.y * v_s2.y;
			pr_s3[10] <= u_s2.x * w_s2.x;
			pr_s3[11] <= u_s2.y * w_s2.y;
			r2_s3     <= r_s2 * r_s2;
		end
	end

	// Sums; squares are non-negative and fit unsigned
	always_comb begin
		n       = SW'(pr_s3[0]) - SW'(pr_s3[1]);
		len2    = $unsigned(pr_s3[2]) + $unsigned(pr_s3[3]);
		da      = $unsigned(pr_s3[4]) + $unsigned(pr_s3[5]);
		db      = $unsigned(pr_s3[6]) + $unsigned(pr_s3[7]);
		dot1    = SW'(pr_s3[8]) + SW'(pr_s3[9]);
		uw      = SW'(pr_s3[10]) + SW'(pr_s3[11]);
		len2_sg = $signed({1'b0, len2});
		nabs    = n[SW-1] ? MW'(-n) : MW'(n);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			nabs_s4  <= nabs;
			len2_s4  <= len2;
			r2_s4    <= r2_s3;
			in_a_s4  <= da < MW'(r2_s3);
			in_b_s4  <= db < MW'(r2_s3);
			d1ge_s4  <= !dot1[SW-1];
			// far end: (A-B).(C-B) is minus u.w
			d2ge_s4  <= uw[SW-1] || (uw == '0);
			// centre on the open segment
			onseg_s4 <= (n == '0) && !dot1[SW-1] && (dot1 != '0) && (dot1 < len2_sg);
		end
	end

	// Partial products of n squared and r squared times length squared
	always_ff @(posedge clk) begin
		if (en.s5) begin
			nh_s5    <= nabs_s4 * nabs_s4[MW-1:HW];
			nl_s5    <= nabs_s4 * nabs_s4[HW-1:0];
			rh_s5    <= r2_s4 * len2_s4[MW-1:HW];
			rl_s5    <= r2_s4 * len2_s4[HW-1:0];
			in_a_s5  <= in_a_s4;
			in_b_s5  <= in_b_s4;
			d1ge_s5  <= d1ge_s4;
			d2ge_s5  <= d2ge_s4;
			onseg_s5 <= onseg_s4;
		end
	end

	always_comb begin
		lhs = (LW'(nh_s5) << HW) + LW'(nl_s5);
		rhs = (LW'(rh_s5) << HW) + LW'(rl_s5);
		res.hit    = in_a_s5 || in_b_s5 || ((lhs < rhs) && d1ge_s5 && d2ge_s5);
		res.in_a   = in_a_s5;
		res.on_seg = onseg_s5;
	end

endmodule

// File: rtl/core/shape_pair_collision_test.sv
// Top level of the shape pair collision test: lane set-up, pipeline control, result.
//
// Usage: one query beat on the s_ channel carries a pair of 2D shapes; s_tuser
// holds the pair code and s_tdata the ten coordinates. One result beat leaves on
// the m_ channel: m_tdata bit 0 is hit, m_tuser is set for an unknown pair code.
// Results leave in the order that queries arrive, exactly one per query.
// Throughput: one query per cycle, sustained while m_tready stays high. A query
// passes through six register stages, the first loaded at the accepting edge
// itself: lane set-up, differences, products, sums and signs, the split
// squaring of the line distance test, and the result register.
// A stalled receiver holds the result register; stages behind it keep filling
// their bubbles, and s_tready falls only once every stage holds a beat.
// Reset empties the pipeline; there is no other state.
module shape_pair_collision_test import shpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// first_ax, first_ay, first_bx, first_by, second_v0x, second_v0y,
	// second_v1x, second_v1y, second_v2x, second_v2y
	input  logic [TDATA_BITS-1:0] s_tdata,
	// kind
	input  logic [3:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// hit, zero pad
	output logic [7:0]            m_tdata,
	// kind_unsupported
	output logic                  m_tuser
);

	logic [3:0] kind;
	point_t fa, fb, s0, s1, t2;
	logic signed [PW-1:0] bxw, byh;
	logic [RW-1:0] fr, sr, rs;
	point_t box_e0 [LANES], box_e1 [LANES], tri_e0 [LANES], tri_e1 [LANES];
	point_t ss_e0 [LANES], ss_e1 [LANES], ss_p0 [LANES], ss_p1 [LANES];
	point_t sc_a [LANES], sc_b [LANES], sc_c [LANES];
	logic [RW-1:0] sc_r [LANES];
	logic eq, boxa, boxb;

	point_t ss_e0_s1 [LANES], ss_e1_s1 [LANES], ss_p0_s1 [LANES], ss_p1_s1 [LANES];
	point_t sc_a_s1 [LANES], sc_b_s1 [LANES], sc_c_s1 [LANES];
	logic [RW-1:0] sc_r_s1 [LANES];
	logic [3:0] kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic [2:0] flg_s1, flg_s2, flg_s3, flg_s4, flg_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	stage_en_t en;
	ss_res_t ss_res [LANES];
	sc_res_t sc_res [LANES];
	logic hit, unsup, hit_s6, unsup_s6;
	logic tri_a, tri_b, any_ss3, any_ss4, any_sc3, any_sc4;

	// Unpack the beat into points
	always_comb begin
		kind = s_tuser;
		fa.x = sext(s_tdata[0*COORD_BITS +: COORD_BITS]);
		fa.y = sext(s_tdata[1*COORD_BITS +: COORD_BITS]);
		fb.x = sext(s_tdata[2*COORD_BITS +: COORD_BITS]);
		fb.y = sext(s_tdata[3*COORD_BITS +: COORD_BITS]);
		s0.x = sext(s_tdata[4*COORD_BITS +: COORD_BITS]);
		s0.y = sext(s_tdata[5*COORD_BITS +: COORD_BITS]);
		s1.x = sext(s_tdata[6*COORD_BITS +: COORD_BITS]);
		s1.y = sext(s_tdata[7*COORD_BITS +: COORD_BITS]);
		t2.x = sext(s_tdata[8*COORD_BITS +: COORD_BITS]);
		t2.y = sext(s_tdata[9*COORD_BITS +: COORD_BITS]);
		bxw  = s0.x + s1.x;
		byh  = s0.y + s1.y;
		// negative radii count as zero
		fr   = fb.x[PW-1] ? '0 : RW'(fb.x);
		sr   = s1.x[PW-1] ? '0 : RW'(s1.x);
		rs   = fr + sr;
	end

	// Box edges left, right, bottom, top; triangle edges, last lane repeats edge zero
	always_comb begin
		box_e0[0] = s0;               box_e1[0] = '{x: s0.x, y: byh};
		box_e0[1] = '{x: bxw, y: s0.y}; box_e1[1] = '{x: bxw, y: byh};
		box_e0[2] = s0;               box_e1[2] = '{x: bxw, y: s0.y};
		box_e0[3] = '{x: s0.x, y: byh}; box_e1[3] = '{x: bxw, y: byh};
		tri_e0[0] = s0; tri_e1[0] = s1;
		tri_e0[1] = s1; tri_e1[1] = t2;
		tri_e0[2] = t2; tri_e1[2] = s0;
		tri_e0[3] = s0; tri_e1[3] = s1;
	end

	// Point tests done at entry
	always_comb begin
		eq   = (fa.x == s0.x) && (fa.y == s0.y);
		boxa = (fa.x > s0.x) && (fa.x < bxw) && (fa.y > s0.y) && (fa.y < byh);
		boxb = (fb.x > s0.x) && (fb.x < bxw) && (fb.y > s0.y) && (fb.y < byh);
	end

	// Lane set-up per pair code
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ss_e0[i] = (kind == KIND_SEG_BOX) ? box_e0[i] : tri_e0[i];
			ss_e1[i] = (kind == KIND_SEG_BOX) ? box_e1[i] : tri_e1[i];
			ss_p0[i] = fa;
			ss_p1[i] = fb;
			sc_a[i]  = (kind == KIND_CIRC_BOX) ? box_e0[i] : tri_e0[i];
			sc_b[i]  = (kind == KIND_CIRC_BOX) ? box_e1[i] : tri_e1[i];
			sc_c[i]  = fa;
			sc_r[i]  = fr;
		end
		if (kind == KIND_SEG_SEG) begin
			ss_e0[0] = fa;
			ss_e1[0] = fb;
			ss_p0[0] = s0;
			ss_p1[0] = s1;
		end
		case (kind)
			KIND_PT_SEG: begin
				sc_a[0] = s0; sc_b[0] = s1; sc_c[0] = fa;
			end
			KIND_PT_CIRC: begin
				sc_a[0] = fa; sc_b[0] = fa; sc_c[0] = s0; sc_r[0] = sr;
			end
			KIND_SEG_CIRC: begin
				sc_a[0] = fa; sc_b[0] = fb; sc_c[0] = s0; sc_r[0] = sr;
			end
			KIND_CIRC_CIRC: begin
				sc_a[0] = fa; sc_b[0] = fa; sc_c[0] = s0; sc_r[0] = rs;
			end
			default: begin
			end
		endcase
	end

	// Stage handshake: each stage loads when empty or when the next one moves
	always_comb begin
		rdy6 = !v_s6 || m_tready;
		rdy5 = !v_s5 || rdy6;
		rdy4 = !v_s4 || rdy5;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		en.s2 = rdy2;
		en.s3 = rdy3;
		en.s4 = rdy4;
		en.s5 = rdy5;
	end

	assign s_tready = rdy1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// Entry stage and side-band carried alongside the lanes
	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int i = 0; i < LANES; i++) begin
				ss_e0_s1[i] <= ss_e0[i];
				ss_e1_s1[i] <= ss_e1[i];
				ss_p0_s1[i] <= ss_p0[i];
				ss_p1_s1[i] <= ss_p1[i];
				sc_a_s1[i]  <= sc_a[i];
				sc_b_s1[i]  <= sc_b[i];
				sc_c_s1[i]  <= sc_c[i];
				sc_r_s1[i]  <= sc_r[i];
			end
			kind_s1 <= kind;
			flg_s1  <= {boxb, boxa, eq};
		end
		if (rdy2) begin kind_s2 <= kind_s1; flg_s2 <= flg_s1; end
		if (rdy3) begin kind_s3 <= kind_s2; flg_s3 <= flg_s2; end
		if (rdy4) begin kind_s4 <= kind_s3; flg_s4 <= flg_s3; end
		if (rdy5) begin kind_s5 <= kind_s4; flg_s5 <= flg_s4; end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		shpc_seg_seg u_ss (
			.clk (clk),
			.en  (en),
			.e0  (ss_e0_s1[g]),
			.e1  (ss_e1_s1[g]),
			.p0  (ss_p0_s1[g]),
			.p1  (ss_p1_s1[g]),
			.res (ss_res[g])
		);
		shpc_seg_circ u_sc (
			.clk (clk),
			.en  (en),
			.a   (sc_a_s1[g]),
			.b   (sc_b_s1[g]),
			.c   (sc_c_s1[g]),
			.r   (sc_r_s1[g]),
			.res (sc_res[g])
		);
	end

	// Combine lane results per pair code
	always_comb begin
		tri_a   = ss_res[0].neg0 && ss_res[1].neg0 && ss_res[2].neg0;
		tri_b   = ss_res[0].neg1 && ss_res[1].neg1 && ss_res[2].neg1;
		any_ss3 = ss_res[0].crs || ss_res[1].crs || ss_res[2].crs;
		any_ss4 = any_ss3 || ss_res[3].crs;
		any_sc3 = sc_res[0].hit || sc_res[1].hit || sc_res[2].hit;
		any_sc4 = any_sc3 || sc_res[3].hit;
		unsup   = 1'b0;
		case (kind_s5)
			KIND_PT_PT:     hit = flg_s5[0];
			KIND_PT_SEG:    hit = sc_res[0].on_seg;
			KIND_PT_CIRC:   hit = sc_res[0].in_a;
			KIND_PT_BOX:    hit = flg_s5[1];
			KIND_PT_TRI:    hit = tri_a;
			KIND_SEG_SEG:   hit = ss_res[0].crs;
			KIND_SEG_CIRC:  hit = sc_res[0].hit;
			KIND_SEG_BOX:   hit = flg_s5[1] || flg_s5[2] || any_ss4;
			KIND_SEG_TRI:   hit = tri_a || tri_b || any_ss3;
			KIND_CIRC_CIRC: hit = sc_res[0].in_a;
			KIND_CIRC_BOX:  hit = flg_s5[1] || any_sc4;
			KIND_CIRC_TRI:  hit = tri_a || any_sc3;
			default: begin
				hit   = 1'b0;
				unsup = 1'b1;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (rdy6) begin
			hit_s6   <= hit;
			unsup_s6 <= unsup;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {7'd0, hit_s6};
	assign m_tuser  = unsup_s6;

`ifndef NO_ASSERTIONS
	// A full pipeline facing a stalled receiver takes no beat
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !m_tready) |-> !s_tready)
		else $error("beat accepted into a full stalled pipeline");

	// A beat waiting at the last lane stage moves into an empty result register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !v_s6) |=> v_s6)
		else $error("result register failed to fill");

	// An unknown pair never reports a hit
	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> !m_tdata[0])
		else $error("hit reported for unknown pair code");
`endif

endmodule
